@@ src/range_encoder_defines.svh @@
// Assertion macros used by renc_checker.
`ifndef RANGE_ENCODER_DEFINES_SVH
`define RANGE_ENCODER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define RE_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define RE_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

@@ src/renc_pkg.sv @@
package renc_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 21;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd3;

    // Input item modes.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    // Block status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_ZEROFREQ = 2'd2;

    localparam logic KIND_RUN    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int unsigned FLUSH_SHIFTS = 5;
    localparam logic [20:0] PENDING_MAX  = 21'h1F_FFFF;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] symbol_value;
        logic [7:0]         table_index;
        logic [16:0]        table_cumulative;
        logic [16:0]        table_frequency;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  byte_value;
        logic [20:0] repeat_count;
        logic [1:0]  status;
        logic [20:0] total_bytes;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_MUL_FREQ,
        S_MUL_CUM,
        S_NORM,
        S_SHIFT,
        S_EMIT_CACHE,
        S_EMIT_PEND,
        S_SHIFT_END,
        S_DONE,
        S_STATUS
    } t_state;

    // Divider handshake.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [16:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

@@ src/renc_in_if.sv @@
interface renc_in_if;
    import renc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/renc_out_if.sv @@
interface renc_out_if;
    import renc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/renc_ram.sv @@
module renc_ram #(
    parameter int unsigned WIDTH = 34,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/renc_div.sv @@
module renc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  renc_pkg::t_div_req i_req,
    output renc_pkg::t_div_rsp o_rsp
);
    import renc_pkg::*;

    logic [31:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [16:0] r_dsr;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [17:0] w_trial;
    logic [17:0] w_diff;

    // One quotient bit per cycle, restoring division.
    always_comb begin
        w_trial = {r_rem, r_quo[31]};
        w_diff  = w_trial - {1'b0, r_dsr};
        n_quo   = {r_quo[30:0], ~w_diff[17]};
        n_rem   = w_diff[17] ? w_trial[16:0] : w_diff[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

@@ src/renc_core.sv @@
module renc_core #(
    parameter int unsigned MAX_SYMBOLS      = 256,
    parameter int unsigned FREQ_BITS        = 16,
    parameter int unsigned MAX_OUTPUT_BYTES = 1048576
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [8:0]              i_alphabet_size,
    input  logic [16:0]             i_total_frequency,
    input  logic signed [9:0]       i_symbol_offset,
    input  logic [20:0]             i_output_capacity,
    renc_in_if.sink                 in_ch,
    renc_out_if.source              out_ch,
    output renc_pkg::t_div_req      o_div_req,
    input  renc_pkg::t_div_rsp      i_div_rsp
);
    import renc_pkg::*;

    localparam int unsigned AW   = $clog2(MAX_SYMBOLS);
    localparam int unsigned TW   = FREQ_BITS + 1;
    localparam logic [16:0] TMASK = 17'((64'd1 << TW) - 64'd1);
    localparam logic [24:0] OUT_MAX = 25'(MAX_OUTPUT_BYTES);

    t_state r_state, n_state;

    logic [32:0] r_low, n_low;
    logic [31:0] r_range, n_range;
    logic [7:0]  r_cache, n_cache;
    logic [20:0] r_pend, n_pend;
    logic [20:0] r_bytes, n_bytes;
    logic [1:0]  r_err, n_err;
    logic [31:0] r_q, n_q;
    logic [31:0] r_prod, n_prod;
    logic [2:0]  r_flush, n_flush;
    logic        r_fin, n_fin;
    logic        r_carry, n_carry;
    logic [AW-1:0] r_idx, n_idx;

    logic      r_ovalid, n_ovalid;
    t_out_item r_odata, n_odata;

    // Most recent run, held back until it is known whether another follows.
    logic      r_hvalid, n_hvalid;
    t_out_item r_hdata, n_hdata;

    // Table memory: cumulative in the high half, frequency in the low half.
    logic            w_we;
    logic [33:0]     w_rdata;
    logic [16:0]     w_cum, w_freq;

    renc_ram #(.WIDTH(34), .DEPTH(MAX_SYMBOLS)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(in_ch.data.table_index)),
        .i_wdata ({in_ch.data.table_cumulative & TMASK,
                   in_ch.data.table_frequency & TMASK}),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );
    assign w_cum  = w_rdata[33:17];
    assign w_freq = w_rdata[16:0];

    // Symbol clamp and effective limits.
    logic signed [17:0] w_sym;
    logic [12:0]        w_alpha;
    logic [24:0]        w_cap;
    logic [16:0]        w_tot;
    logic               w_accept;
    logic               w_load_ok;

    always_comb begin
        w_alpha = (i_alphabet_size == 9'd0) ? 13'd1 : 13'(i_alphabet_size);
        if (w_alpha > 13'(MAX_SYMBOLS)) begin
            w_alpha = 13'(MAX_SYMBOLS);
        end
        w_sym = 18'(in_ch.data.symbol_value) + 18'(i_symbol_offset);
        w_cap = (25'(i_output_capacity) > OUT_MAX) ? OUT_MAX : 25'(i_output_capacity);
        w_tot = (i_total_frequency == 17'd0) ? 17'd1 : i_total_frequency;
        w_accept  = in_ch.valid && in_ch.ready;
        w_load_ok = 32'(in_ch.data.table_index) < 32'(MAX_SYMBOLS);
    end

    assign w_we = w_accept && (in_ch.data.mode == MODE_LOAD) && w_load_ok;

    // Shift decision helpers.
    logic       w_resolve;
    logic [24:0] w_run_n;
    logic       w_fits_one, w_fits_pend;
    always_comb begin
        w_resolve   = (r_low < 33'hFF00_0000) || r_low[32];
        w_fits_one  = (25'(r_bytes) + 25'd1) <= w_cap;
        w_run_n     = 25'(r_bytes) + 25'(r_pend);
        w_fits_pend = (25'(r_pend) <= w_cap) && (w_run_n <= w_cap);
    end

    logic w_out_free;
    logic w_hold_free;
    assign w_out_free  = !r_ovalid || out_ch.ready;
    assign w_hold_free = !r_hvalid || w_out_free;

    assign in_ch.ready = (r_state == S_IDLE);
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_odata;

    always_comb begin
        o_div_req.start    = (r_state == S_READ);
        o_div_req.dividend = r_range;
        o_div_req.divisor  = w_tot;
    end

    // Sequencer: next state, datapath updates, output staging.
    always_comb begin
        n_state  = r_state;
        n_low    = r_low;
        n_range  = r_range;
        n_cache  = r_cache;
        n_pend   = r_pend;
        n_bytes  = r_bytes;
        n_err    = r_err;
        n_q      = r_q;
        n_prod   = r_prod;
        n_flush  = r_flush;
        n_fin    = r_fin;
        n_carry  = r_carry;
        n_idx    = r_idx;
        n_ovalid = r_ovalid && !out_ch.ready;
        n_odata  = r_odata;
        n_hvalid = r_hvalid;
        n_hdata  = r_hdata;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (in_ch.data.mode == MODE_ENCODE && r_err == ST_OK) begin
                        if (w_sym < 0) begin
                            n_idx = '0;
                        end else if (w_sym >= 18'(w_alpha)) begin
                            n_idx = AW'(w_alpha - 13'd1);
                        end else begin
                            n_idx = AW'(w_sym);
                        end
                        n_state = S_READ;
                    end else if (in_ch.data.mode == MODE_FINISH) begin
                        n_fin   = 1'b1;
                        n_flush = 3'd0;
                        n_state = (r_err == ST_OK) ? S_SHIFT : S_STATUS;
                    end
                end
            end
            S_READ: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    n_q     = i_div_rsp.quotient;
                    n_state = S_MUL_FREQ;
                end
            end
            S_MUL_FREQ: begin
                n_prod = 32'(64'(w_freq) * 64'(r_q));
                n_state = S_MUL_CUM;
            end
            S_MUL_CUM: begin
                if (r_prod == 32'd0) begin
                    n_err   = ST_ZEROFREQ;
                    n_state = S_IDLE;
                end else begin
                    n_low   = 33'(64'(r_low) + 64'(w_cum) * 64'(r_q));
                    n_range = r_prod;
                    n_fin   = 1'b0;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (r_range < 32'h0100_0000) begin
                    n_range = {r_range[23:0], 8'd0};
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                n_carry = r_low[32];
                if (w_resolve) begin
                    n_state = S_EMIT_CACHE;
                end else begin
                    if (r_pend < PENDING_MAX) begin
                        n_pend = r_pend + 21'd1;
                    end
                    n_state = S_SHIFT_END;
                end
            end
            S_EMIT_CACHE: begin
                if (!w_fits_one) begin
                    n_err   = ST_OVERFLOW;
                    n_state = S_DONE;
                end else if (w_hold_free) begin
                    if (r_hvalid) begin
                        n_ovalid = 1'b1;
                        n_odata  = r_hdata;
                    end
                    n_hvalid = 1'b1;
                    n_hdata  = '{kind: KIND_RUN, byte_value: r_cache + 8'(r_carry),
                                 repeat_count: 21'd1, status: ST_OK, total_bytes: '0,
                                 last: 1'b0};
                    n_bytes  = r_bytes + 21'd1;
                    n_state  = (r_pend != 21'd0) ? S_EMIT_PEND : S_SHIFT_END;
                    if (r_pend == 21'd0) begin
                        n_cache = r_low[31:24];
                    end
                end
            end
            S_EMIT_PEND: begin
                if (!w_fits_pend) begin
                    n_err   = ST_OVERFLOW;
                    n_state = S_DONE;
                end else if (w_hold_free) begin
                    if (r_hvalid) begin
                        n_ovalid = 1'b1;
                        n_odata  = r_hdata;
                    end
                    n_hvalid = 1'b1;
                    n_hdata  = '{kind: KIND_RUN, byte_value: r_carry ? 8'h00 : 8'hFF,
                                 repeat_count: r_pend, status: ST_OK, total_bytes: '0,
                                 last: 1'b0};
                    n_bytes  = w_run_n[20:0];
                    n_pend   = '0;
                    n_cache  = r_low[31:24];
                    n_state  = S_SHIFT_END;
                end
            end
            S_SHIFT_END: begin
                n_low = {1'b0, r_low[23:0], 8'd0};
                if (r_fin) begin
                    n_flush = r_flush + 3'd1;
                    n_state = (r_flush == 3'(FLUSH_SHIFTS - 1)) ? S_DONE : S_SHIFT;
                end else begin
                    n_state = S_NORM;
                end
            end
            // Release the held run; it closes an encode item but not a finish.
            S_DONE: begin
                if (!r_hvalid) begin
                    n_state = r_fin ? S_STATUS : S_IDLE;
                end else if (w_out_free) begin
                    n_ovalid     = 1'b1;
                    n_odata      = r_hdata;
                    n_odata.last = !r_fin;
                    n_hvalid     = 1'b0;
                    n_state      = r_fin ? S_STATUS : S_IDLE;
                end
            end
            S_STATUS: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = '{kind: KIND_STATUS, byte_value: 8'd0, repeat_count: '0,
                                 status: r_err, total_bytes: r_bytes, last: 1'b1};
                    n_low   = '0;
                    n_range = '1;
                    n_cache = '0;
                    n_pend  = '0;
                    n_bytes = '0;
                    n_err   = ST_OK;
                    n_fin   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and coder state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_low    <= '0;
            r_range  <= '1;
            r_cache  <= '0;
            r_pend   <= '0;
            r_bytes  <= '0;
            r_err    <= ST_OK;
            r_fin    <= 1'b0;
            r_flush  <= '0;
            r_ovalid <= 1'b0;
            r_hvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_low    <= n_low;
            r_range  <= n_range;
            r_cache  <= n_cache;
            r_pend   <= n_pend;
            r_bytes  <= n_bytes;
            r_err    <= n_err;
            r_fin    <= n_fin;
            r_flush  <= n_flush;
            r_ovalid <= n_ovalid;
            r_hvalid <= n_hvalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_q     <= n_q;
        r_prod  <= n_prod;
        r_carry <= n_carry;
        r_idx   <= n_idx;
        r_odata <= n_odata;
        r_hdata <= n_hdata;
    end
endmodule

@@ src/range_encoder.sv @@
// Range encoder with a static frequency model and a carry cache.
// Input channel in_ch carries one transaction per item: mode 0 loads one
// cumulative/frequency table entry, mode 1 encodes a symbol, mode 2 ends
// the block. Output channel out_ch carries byte runs (value, repeat count)
// and, on finish, a status transaction with the block's byte count; the
// last transaction caused by an input has last set.
// Configuration is written through i_cfg_we, i_cfg_index, i_cfg_data; the user
// must write it only while the block is idle, as the block has no check for it.
// A load writes one table entry. An encode item runs a table read, the
// bit-serial divider, two multiply steps and the end of the item; each
// renormalising byte shift adds its shift and emit steps. A finish runs
// five flush shifts and the status transaction.
// One item is worked on at a time; in_ch is ready only while idle.
// The newest run is held back so that its last flag is known;
// a stalled receiver holds the sequencer once that run has to move on.
// Reset restores the configuration and control registers and the coder
// state; table entries stay undefined until loaded.
module range_encoder #(
    parameter int unsigned MAX_SYMBOLS      = 256,
    parameter int unsigned FREQ_BITS        = 16,
    parameter int unsigned MAX_OUTPUT_BYTES = 1048576
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [renc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [renc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    renc_in_if.sink                            in_ch,
    renc_out_if.source                         out_ch
);
    import renc_pkg::*;

    logic [8:0]        r_alphabet;
    logic [16:0]       r_total;
    logic signed [9:0] r_offset;
    logic [20:0]       r_capacity;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet <= 9'd256;
            r_total    <= 17'd65536;
            r_offset   <= '0;
            r_capacity <= 21'd1048576;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ALPHABET: r_alphabet <= i_cfg_data[8:0];
                REG_TOTAL:    r_total    <= i_cfg_data[16:0];
                REG_OFFSET:   r_offset   <= i_cfg_data[9:0];
                REG_CAPACITY: r_capacity <= i_cfg_data[20:0];
                default: ;
            endcase
        end
    end

    renc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    renc_core #(
        .MAX_SYMBOLS      (MAX_SYMBOLS),
        .FREQ_BITS        (FREQ_BITS),
        .MAX_OUTPUT_BYTES (MAX_OUTPUT_BYTES)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_alphabet_size   (r_alphabet),
        .i_total_frequency (r_total),
        .i_symbol_offset   (r_offset),
        .i_output_capacity (r_capacity),
        .in_ch             (in_ch),
        .out_ch            (out_ch),
        .o_div_req         (w_div_req),
        .i_div_rsp         (w_div_rsp)
    );
endmodule

@@ src/renc_checker.sv @@
`include "range_encoder_defines.svh"
module renc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic [1:0] in_mode,
    input logic out_valid,
    input logic out_ready,
    input logic out_kind,
    input logic out_last,
    input logic [20:0] out_repeat
);
    import renc_pkg::*;

    // A status transaction always closes the results of its input.
    `RE_ASSERT_IMP(a_status_last, i_clk, i_rst_n, out_valid && out_kind, out_last, "status without last")
    // A byte run never carries a zero repeat count.
    `RE_ASSERT_IMP(a_run_nonzero, i_clk, i_rst_n, out_valid && !out_kind, out_repeat != 21'd0, "empty run")
    // A stalled result stays offered.
    `RE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid, "result dropped")
    // A stalled result keeps its contents.
    `RE_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, out_valid && !out_ready, $stable({out_kind, out_last, out_repeat}), "result changed")
    // A finish keeps the input closed in the following cycle.
    `RE_ASSERT_NXT(a_finish_busy, i_clk, i_rst_n, in_valid && in_ready && in_mode == MODE_FINISH, !in_ready, "input open during finish")
endmodule

bind range_encoder renc_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_mode    (in_ch.data.mode),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_kind   (out_ch.data.kind),
    .out_last   (out_ch.data.last),
    .out_repeat (out_ch.data.repeat_count)
);

@@ tb/sv/range_encoder_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels and the register port of the range encoder, predicts
// every output transaction and compares it with what the block sends.
module range_encoder_checker
    import renc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    renc_in_if                    in_ch,
    renc_out_if                   out_ch,
    output int                    o_errors,
    output int                    o_outstanding
);

    localparam int unsigned SYMBOLS   = 256;
    localparam int unsigned OUT_LIMIT = 1048576;

    // Register copies.
    logic [8:0]  alpha_reg;
    logic [16:0] total_reg;
    logic [9:0]  offset_reg;
    logic [20:0] capacity_reg;

    // Coder state.
    logic [32:0] low_acc;
    logic [31:0] range_acc;
    logic [7:0]  cache_byte;
    logic [20:0] pend_cnt;
    logic [20:0] byte_cnt;
    logic [1:0]  err_code;
    logic [16:0] cum_tab [SYMBOLS];
    logic [16:0] freq_tab [SYMBOLS];

    t_out_item item_runs[$];
    t_out_item expected_runs[$];

    assign o_outstanding = expected_runs.size();

    function automatic void clear_coder();
        low_acc    = '0;
        range_acc  = 32'hFFFF_FFFF;
        cache_byte = '0;
        pend_cnt   = '0;
        byte_cnt   = '0;
        err_code   = ST_OK;
    endfunction

    function automatic void raise_error(logic [1:0] code);
        if (err_code == ST_OK) begin
            err_code = code;
        end
    endfunction

    // Queues one byte run unless it would take the block past its capacity.
    function automatic bit push_run(logic [7:0] value, int unsigned count);
        int unsigned cap;
        t_out_item   run;
        cap = (capacity_reg > OUT_LIMIT) ? OUT_LIMIT : capacity_reg;
        if (count > cap || int'(byte_cnt) > cap - count) begin
            raise_error(ST_OVERFLOW);
            return 0;
        end
        run              = '0;
        run.kind         = KIND_RUN;
        run.byte_value   = value;
        run.repeat_count = count[20:0];
        item_runs.push_back(run);
        byte_cnt = byte_cnt + count[20:0];
        return 1;
    endfunction

    // One byte shift of the low register, resolving the carry where it can.
    function automatic bit shift_byte();
        logic carry;
        carry = low_acc[32];
        if (low_acc < 33'h0_FF00_0000 || carry) begin
            if (!push_run(cache_byte + {7'd0, carry}, 1)) return 0;
            if (pend_cnt != 0) begin
                if (!push_run(carry ? 8'h00 : 8'hFF, pend_cnt)) return 0;
                pend_cnt = '0;
            end
            cache_byte = low_acc[31:24];
        end else if (pend_cnt < PENDING_MAX) begin
            pend_cnt = pend_cnt + 1'b1;
        end
        low_acc = {1'b0, low_acc[23:0], 8'h00};
        return 1;
    endfunction

    function automatic void code_symbol(logic signed [15:0] value);
        int          alpha;
        int          sym;
        logic [31:0] tot;
        logic [31:0] quot;
        logic [63:0] prod;
        if (err_code != ST_OK) return;
        alpha = (alpha_reg == 0) ? 1 : ((alpha_reg > SYMBOLS) ? SYMBOLS : alpha_reg);
        tot   = (total_reg == 0) ? 32'd1 : {15'd0, total_reg};
        sym   = int'(value) + int'($signed(offset_reg));
        if (sym < 0) sym = 0;
        else if (sym >= alpha) sym = alpha - 1;
        quot = range_acc / tot;
        prod = {47'd0, freq_tab[sym]} * {32'd0, quot};
        if (prod[31:0] == 0) begin
            raise_error(ST_ZEROFREQ);
            return;
        end
        prod      = {47'd0, cum_tab[sym]} * {32'd0, quot};
        low_acc   = low_acc + prod[32:0];
        range_acc = prod[31:0] == 0 ? range_acc : range_acc;
        prod      = {47'd0, freq_tab[sym]} * {32'd0, quot};
        range_acc = prod[31:0];
        while (range_acc < 32'h0100_0000) begin
            range_acc = range_acc << 8;
            if (!shift_byte()) return;
        end
    endfunction

    function automatic void close_block();
        t_out_item stat;
        if (err_code == ST_OK) begin
            for (int i = 0; i < FLUSH_SHIFTS; i++) begin
                if (!shift_byte()) break;
            end
        end
        stat             = '0;
        stat.kind        = KIND_STATUS;
        stat.status      = err_code;
        stat.total_bytes = byte_cnt;
        item_runs.push_back(stat);
        clear_coder();
    endfunction

    // Predicts the transactions caused by one accepted input item.
    function automatic void predict_item(t_in_item it);
        item_runs.delete();
        case (it.mode)
            MODE_LOAD: begin
                cum_tab[it.table_index]  = it.table_cumulative;
                freq_tab[it.table_index] = it.table_frequency;
            end
            MODE_ENCODE: code_symbol(it.symbol_value);
            MODE_FINISH: close_block();
            default: ;
        endcase
        if (item_runs.size() > 0) begin
            item_runs[item_runs.size()-1].last = 1'b1;
        end
        foreach (item_runs[i]) expected_runs.push_back(item_runs[i]);
    endfunction

    // Register writes, input prediction and output comparison.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            alpha_reg    <= 9'd256;
            total_reg    <= 17'd65536;
            offset_reg   <= '0;
            capacity_reg <= 21'd1048576;
            clear_coder();
            expected_runs.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ALPHABET: alpha_reg    <= i_cfg_data[8:0];
                    REG_TOTAL:    total_reg    <= i_cfg_data[16:0];
                    REG_OFFSET:   offset_reg   <= i_cfg_data[9:0];
                    REG_CAPACITY: capacity_reg <= i_cfg_data[20:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_item(in_ch.data);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_runs.size() == 0) begin
                    if (o_errors < 10) begin
                        $display("ERROR: unexpected output transaction %h", out_ch.data);
                    end
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_runs.pop_front();
                    if (want !== out_ch.data) begin
                        if (o_errors < 10) begin
                            $display("ERROR: expected kind %0d byte %h count %0d st %0d tot %0d last %0d",
                                     want.kind, want.byte_value, want.repeat_count,
                                     want.status, want.total_bytes, want.last);
                            $display("       actual   kind %0d byte %h count %0d st %0d tot %0d last %0d",
                                     out_ch.data.kind, out_ch.data.byte_value,
                                     out_ch.data.repeat_count, out_ch.data.status,
                                     out_ch.data.total_bytes, out_ch.data.last);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import renc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 120;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    waiting_runs;
    int                    cycle_cnt;
    int                    burst_left;
    int                    hold_seq;

    // Coder settings as last written, used to steer symbols onto loaded entries.
    int cur_alpha;
    int cur_total;
    int cur_offset;
    bit loaded [256];

    renc_in_if  in_ch ();
    renc_out_if out_ch ();

    range_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    range_encoder_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .o_errors      (fail_count),
        .o_outstanding (waiting_runs)
    );

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit.
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: changing stall patterns, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        static int pattern  = 0;
        static int span     = 0;
        static int hold_cnt = 0;
        static int seen_seq = 0;
        if (hold_cnt == 0 && hold_seq != seen_seq) begin
            seen_seq = hold_seq;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            out_ch.ready <= 1'b0;
            hold_cnt = hold_cnt - 1;
        end else begin
            if (span == 0) begin
                pattern = $urandom_range(0, 3);
                span    = $urandom_range(16, 96);
            end
            span = span - 1;
            case (pattern)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                2: out_ch.ready <= ((cycle_cnt % 4) == 0);
                default: out_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Offers one item and holds it until the block takes it, then maybe pauses.
    task automatic send_item(t_in_item it);
        bit took;
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        if (it.mode == MODE_LOAD) loaded[it.table_index] = 1;
        do begin
            @(negedge i_clk);
            took = in_ch.ready;
            @(posedge i_clk);
        end while (!took);
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 10);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Lowers valid and waits until every predicted transaction has arrived.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (waiting_runs != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Full set of coder settings; sizes are taken the way the block clamps them.
    task automatic configure(int alpha, int total, int offset, int cap);
        drain();
        write_reg(REG_ALPHABET, alpha);
        write_reg(REG_TOTAL, total);
        write_reg(REG_OFFSET, offset);
        write_reg(REG_CAPACITY, cap);
        cur_alpha  = (alpha % 512 == 0) ? 1 : ((alpha % 512 > 256) ? 256 : alpha % 512);
        cur_total  = (total % 131072 == 0) ? 1 : total % 131072;
        cur_offset = offset;
    endtask

    function automatic int symbol_slot(logic signed [15:0] value);
        int sym;
        sym = int'(value) + cur_offset;
        if (sym < 0) return 0;
        if (sym >= cur_alpha) return cur_alpha - 1;
        return sym;
    endfunction

    task automatic load_entry(int idx, int cum, int freq);
        t_in_item it;
        it                  = '0;
        it.mode             = MODE_LOAD;
        it.symbol_value     = 16'($urandom());
        it.table_index      = idx[7:0];
        it.table_cumulative = cum[16:0];
        it.table_frequency  = freq[16:0];
        send_item(it);
    endtask

    task automatic load_random(int idx);
        int freq;
        int cum;
        cum  = $urandom_range(0, cur_total);
        freq = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, cur_total);
        if ($urandom_range(0, 9) == 0) begin
            cum  = $urandom_range(0, 131071);
            freq = $urandom_range(0, 131071);
        end
        load_entry(idx, cum, freq);
    endtask

    // Encodes a value, loading its table entry first if it was never written.
    task automatic encode_value(logic signed [15:0] value);
        t_in_item it;
        int       slot;
        slot = symbol_slot(value);
        if (!loaded[slot]) load_random(slot);
        it                  = '0;
        it.mode             = MODE_ENCODE;
        it.symbol_value     = value;
        it.table_index      = 8'($urandom());
        it.table_cumulative = 17'($urandom());
        it.table_frequency  = 17'($urandom());
        send_item(it);
    endtask

    task automatic plain_item(logic [1:0] mode);
        t_in_item it;
        it                  = '0;
        it.mode             = mode;
        it.symbol_value     = 16'($urandom());
        it.table_index      = 8'($urandom());
        it.table_cumulative = 17'($urandom());
        it.table_frequency  = 17'($urandom());
        send_item(it);
    endtask

    // Random phase: mostly blocks of well-formed encodes, with some noise.
    task automatic random_phase(int count);
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 19);
            if (sel < 13) begin
                if ($urandom_range(0, 3) == 0) begin
                    encode_value(16'($urandom()));
                end else begin
                    encode_value(16'(int'($urandom_range(0, cur_alpha - 1)) - cur_offset));
                end
            end else if (sel < 16) begin
                plain_item(MODE_FINISH);
            end else if (sel < 18) begin
                load_random($urandom_range(0, 255));
            end else if (sel < 19) begin
                plain_item(2'd3);
            end else begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (waiting_runs != 0) @(posedge i_clk);
            end
            if (n == count / 3) hold_seq = hold_seq + 1;
        end
        plain_item(MODE_FINISH);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        hold_seq    = 0;
        burst_left  = 1;
        cur_alpha   = 256;
        cur_total   = 65536;
        cur_offset  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: table extremes, clamping at both ends, zero frequency, unused mode.
        load_entry(0, 0, 32768);
        load_entry(255, 65536, 65536);
        load_entry(128, 131071, 131071);
        load_entry(7, 1000, 0);
        encode_value(16'sh8000);
        encode_value(16'sh7FFF);
        encode_value(16'sd0);
        encode_value(16'sd255);
        encode_value(16'sd128);
        plain_item(MODE_FINISH);
        plain_item(2'd3);
        encode_value(16'sd7);
        encode_value(16'sd0);
        plain_item(MODE_FINISH);

        // Smallest settings: one symbol, divisor one, offset -256, capacity zero, then six.
        configure(1, 1, -256, 0);
        load_entry(0, 0, 1);
        encode_value(16'sd0);
        encode_value(16'sh7FFF);
        plain_item(MODE_FINISH);
        configure(1, 0, -256, 6);
        encode_value(16'sd5);
        plain_item(MODE_FINISH);

        // Settings beyond the clamp points.
        configure(511, 65536, 256, 2097151);
        encode_value(16'sh8000);
        plain_item(MODE_FINISH);

        // Random phases over several settings.
        configure(256, 65536, 0, 1048576);
        random_phase(25);
        configure(16, 256, 3, 2097151);
        random_phase(20);
        configure(4, 16, -2, 12);
        random_phase(15);
        configure($urandom_range(1, 300), $urandom_range(1, 65536),
                  $urandom_range(0, 512) - 256, $urandom_range(20, 200));
        random_phase(20);

        drain();
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ range_encoder.f @@
+incdir+src
src/renc_pkg.sv
src/renc_in_if.sv
src/renc_out_if.sv
src/renc_ram.sv
src/renc_div.sv
src/renc_core.sv
src/range_encoder.sv
src/renc_checker.sv
tb/sv/range_encoder_checker.sv
tb/sv/tb.sv
